// ===== src/ibl_pkg.sv =====
// ----------------------------------------------------------------------------
// ibl_pkg
// Shared field widths, operation codes and beat types for the indexed byte list.
// ----------------------------------------------------------------------------
package ibl_pkg;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 4;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 5;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

    // request beat
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } ibl_req_t;

    // response beat
    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  count;
    } ibl_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic exec;
    } ibl_cmd_t;

endpackage

// ===== src/ibl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibl_ctrl
// Handshake controller: tracks whether the response register holds a beat.
// ----------------------------------------------------------------------------
module ibl_ctrl
    import ibl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ibl_cmd_t cmd
);

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_HOLD  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // a new request may enter when no response is held or when the held response leaves this cycle
    assign req_ready = (state_reg == ST_EMPTY) || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = (state_reg == ST_HOLD);
    assign cmd.exec  = accept;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
                else if (rsp_ready)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/ibl_dp.sv =====
// ----------------------------------------------------------------------------
// ibl_dp
// Datapath: register cells with parallel shift, entry count, response register.
// ----------------------------------------------------------------------------
module ibl_dp
    import ibl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  ibl_cmd_t                           cmd,
    input  ibl_req_t                           req,
    output ibl_rsp_t                           rsp,
    output logic [$clog2(CAPACITY + 1)-1:0]    list_count
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int XW   = (CW > IDX_W) ? CW : IDX_W;
    localparam int OW   = (CW > CNT_W) ? CW : CNT_W;
    localparam int RD_N = (CAPACITY < (2 ** IDX_W)) ? CAPACITY : (2 ** IDX_W);

    logic [DATA_W-1:0] cell_reg  [CAPACITY];
    logic [DATA_W-1:0] cell_next [CAPACITY];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [OW-1:0]     count_ext;
    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     cnt_x;
    logic              in_range;
    logic              room;
    logic              op_ok;
    logic [DATA_W-1:0] rd_sel;
    ibl_rsp_t          rsp_reg;
    ibl_rsp_t          rsp_next;

    // index check and read select
    always_comb
    begin
        idx_x    = XW'(req.index);
        cnt_x    = XW'(count_reg);
        in_range = idx_x < cnt_x;
        room     = count_reg != CW'(CAPACITY);
        rd_sel   = '0;
        for (int j = 0; j < RD_N; j++)
        begin
            if (req.index == IDX_W'(j))
            begin
                rd_sel = cell_reg[j];
            end
        end
        unique case (req.op) inside
            OP_READ, OP_WRITE, OP_REMOVE:
            begin
                op_ok = in_range;
            end
            OP_INSERT:
            begin
                op_ok = (idx_x <= cnt_x) && room;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec && op_ok)
        begin
            case (req.op)
                OP_INSERT: count_next = count_reg + CW'(1);
                OP_REMOVE: count_next = count_reg - CW'(1);
                default:   count_next = count_reg;
            endcase
        end
    end

    // every cell picks its own next value: hold, load, or take a neighbor
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (op_ok)
            begin
                case (req.op)
                    OP_WRITE:
                    begin
                        if (idx_x == XW'(i))
                        begin
                            cell_next[i] = req.value;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (idx_x == XW'(i))
                        begin
                            cell_next[i] = req.value;
                        end
                        else if ((i > 0) && (idx_x < XW'(i)))
                        begin
                            cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                    OP_REMOVE:
                    begin
                        if ((i < CAPACITY - 1) && (idx_x <= XW'(i)))
                        begin
                            cell_next[i] = cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
                        end
                    end
                    default:
                    begin
                        cell_next[i] = cell_reg[i];
                    end
                endcase
            end
        end
    end

    // response beat
    always_comb
    begin
        count_ext          = OW'(count_next);
        rsp_next.ok        = op_ok;
        rsp_next.read_data = (op_ok && (req.op == OP_READ)) ? rd_sel : '0;
        rsp_next.count     = count_ext[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            cell_reg <= cell_next;
            rsp_reg  <= rsp_next;
        end
    end

    assign rsp        = rsp_reg;
    assign list_count = count_reg;

endmodule

// ===== src/indexed_byte_list.sv =====
// ----------------------------------------------------------------------------
// indexed_byte_list
// Ordered list of byte entries with read, write, insert and remove by index.
// ----------------------------------------------------------------------------
//
//  channel  signals                      beat          direction
//  req      req_valid, req_ready, req    ibl_req_t     in
//  rsp      rsp_valid, rsp_ready, rsp    ibl_rsp_t     out
//
//  for every request the index check, the parallel shift of all register
//  cells and the response register load happen at the accepting edge
//  the response is visible the cycle after acceptance; one beat per cycle
//  is sustained while rsp_ready stays high
//  a stalled response holds its register; a new request enters in the same
//  cycle that the held response is taken
//  reset clears the entry count and the response valid; cells are not reset
//
module indexed_byte_list
    import ibl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ibl_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ibl_rsp_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    ibl_cmd_t      cmd;
    logic [CW-1:0] list_count;

    // handshake controller
    ibl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    // list cells, count and response register
    ibl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req        (req),
        .rsp        (rsp),
        .list_count (list_count)
    );

    // reads and writes never change the entry count
    a_rw_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && ((req.op == OP_READ) || (req.op == OP_WRITE)))
        |=> (list_count == $past(list_count)))
    else $error("read or write changed the entry count");

    // an accepted request always yields a response beat next cycle
    a_accept_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
    else $error("accepted request produced no response");

    // a refused request carries zero read data
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> (rsp.read_data == '0))
    else $error("refused response carries read data");

    // insert into a full list is refused
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.op == OP_INSERT) && (list_count == CW'(CAPACITY)))
        |=> !rsp.ok)
    else $error("insert into full list accepted");

endmodule
